// File: design/mic_pkg.sv
// ----------------------------------------------------------------------------
// Matrix inverse by cofactors: shared package
// Sizes, payload structs and constants for the cofactor inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package mic_pkg;

  // largest matrix order and the widths that follow from it
  localparam int MAX_ORDER = 4;
  localparam int ORDER_W   = $clog2(MAX_ORDER + 1);
  localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int POS_W  = 3;
  localparam int CFG_W  = 4;

  // arithmetic widths
  localparam int PROD_W    = 2 * VAL_W;
  localparam int TERM_W    = PROD_W - FRAC_W;
  localparam int SUM_W     = TERM_W + IDX_W;
  localparam int DIV_NUM_W = VAL_W + FRAC_W + 1;
  localparam int DIV_DEN_W = VAL_W + 1;

  localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [ORDER_W-1:0]      ORDER_RESET = ORDER_W'(4);

  typedef struct packed {
    logic signed [VAL_W-1:0] element_value;
    logic                    last_element;
  } elem_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] inverse_value;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    singular;
    logic                    last_result;
  } result_t;

  // mask with the low n bits set
  function automatic logic [MAX_ORDER-1:0] order_mask(input logic [ORDER_W-1:0] n);
    logic [MAX_ORDER-1:0] m;
    for (int i = 0; i < MAX_ORDER; i++) begin
      m[i] = (ORDER_W'(i) < n);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: design/mic_div.sv
// ----------------------------------------------------------------------------
// Matrix inverse by cofactors: serial divider
// Unsigned restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mic_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [mic_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [mic_pkg::DIV_DEN_W-1:0] den,
  output logic                               done,
  output logic [mic_pkg::DIV_NUM_W-1:0]      quot
);

  localparam int NW    = mic_pkg::DIV_NUM_W;
  localparam int DW    = mic_pkg::DIV_DEN_W;
  localparam int STEPW = $clog2(NW + 1);

  logic              running;
  logic [STEPW-1:0]  step;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     den_r;
  logic [NW-1:0]     dvd;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic              fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, dvd[NW-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = (shifted >= {1'b0, den_r});
  end

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEPW'(NW - 1);
        rem     <= '0;
        den_r   <= den;
        dvd     <= num;
        quot    <= '0;
      end else if (running) begin
        rem  <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        dvd  <= {dvd[NW-2:0], 1'b0};
        quot <= {quot[NW-2:0], fits};
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // the divider never sees a start while it runs
  assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider restarted while busy");

  assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider done while still running");

  assert property (@(posedge clk) disable iff (rst) start |=> running)
    else $error("divider did not start");

endmodule

`default_nettype wire

// File: design/matrix_inverse_by_cofactors.sv
// ----------------------------------------------------------------------------
// Matrix inverse by cofactors
// Loads a square Q16.16 matrix, expands the determinant and every cofactor
// along the first row with one shared 32x32 multiplier and a frame stack,
// then divides each signed cofactor by the determinant in a serial divider.
// Sequence: the recursion works through a scan, a multiply and an accumulate
// per term, and each inverse element then takes a serial division.
// Throughput: one matrix at a time; elem_ready is low until the last beat.
// Reset: synchronous; clears control state, order returns to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_by_cofactors (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      elem_valid,
  output logic                           elem_ready,
  input  wire mic_pkg::elem_t            elem,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output mic_pkg::result_t               result,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [mic_pkg::CFG_W-1:0] cfg_data
);

  localparam int MO  = mic_pkg::MAX_ORDER;
  localparam int OW  = mic_pkg::ORDER_W;
  localparam int IW  = mic_pkg::IDX_W;
  localparam int AW  = mic_pkg::ADDR_W;
  localparam int CW  = mic_pkg::CNT_W;
  localparam int VW  = mic_pkg::VAL_W;
  localparam int PW  = mic_pkg::PROD_W;
  localparam int TW  = mic_pkg::TERM_W;
  localparam int SW  = mic_pkg::SUM_W;
  localparam int FW  = mic_pkg::FRAC_W;
  localparam int NW  = mic_pkg::DIV_NUM_W;
  localparam int DW  = mic_pkg::DIV_DEN_W;
  localparam int XW  = mic_pkg::POS_W;

  typedef enum logic [2:0] {
    S_LOAD, S_CALL, S_SCAN, S_MUL, S_ACC, S_DIV, S_OUT
  } state_t;

  state_t                 state;
  logic [mic_pkg::CFG_W-1:0] order_reg;
  logic [CW-1:0]          load_count;
  logic [OW-1:0]          n;
  logic [OW-1:0]          root_k;
  logic                   phase_det;
  logic [IW-1:0]          lv;
  logic signed [VW-1:0]   child_res;
  logic signed [PW-1:0]   prod;
  logic signed [VW-1:0]   det;
  logic                   sing;
  logic [IW-1:0]          out_r;
  logic [IW-1:0]          out_c;
  logic                   q_neg;

  // expansion frames, one per recursion level
  logic [MO-1:0]          rows_stk [MO];
  logic [MO-1:0]          cols_stk [MO];
  logic [OW-1:0]          c_stk    [MO];
  logic [IW-1:0]          r_stk    [MO];
  logic                   neg_stk  [MO];
  logic signed [SW-1:0]   sum_stk  [MO];

  logic signed [VW-1:0]   matrix_store [mic_pkg::DEPTH];

  // ---------------- combinational helpers ----------------
  logic [OW-1:0]          n_in;
  logic [MO-1:0]          full_in;
  logic [MO-1:0]          full_n;
  logic [2*OW-1:0]        nn_in;
  logic [MO-1:0]          cur_rows;
  logic [MO-1:0]          cur_cols;
  logic [OW-1:0]          cur_c;
  logic [IW-1:0]          cur_r;
  logic signed [SW-1:0]   cur_sum;
  logic [IW-1:0]          low_r;
  logic signed [VW-1:0]   sat_sum;
  logic [OW-1:0]          k_child;
  logic                   fin;
  logic signed [VW-1:0]   fin_val;
  logic [IW-1:0]          lv_rd;
  logic [2*OW-1:0]        rd_addr_w;
  logic signed [VW-1:0]   rd_elem;
  logic signed [PW-1:0]   mul_res;
  logic signed [PW-1:0]   rounded;
  logic signed [SW-1:0]   term;
  logic [VW-1:0]          cof_abs;
  logic [VW-1:0]          det_abs;
  logic [NW-1:0]          div_num;
  logic [DW-1:0]          div_den;
  logic                   div_start;
  logic                   div_done;
  logic [NW-1:0]          div_quot;
  logic [VW-1:0]          q_clamp;
  logic signed [VW-1:0]   q_val;
  logic                   is_last;
  logic [IW-1:0]          nxt_r;
  logic [IW-1:0]          nxt_c;
  logic                   elem_beat;

  assign elem_ready = (state == S_LOAD);
  assign cfg_ready  = 1'b1;
  assign elem_beat  = elem_valid && elem_ready;

  // clamp the configured order and size the load
  always_comb begin
    if (order_reg == '0) begin
      n_in = OW'(1);
    end else if (order_reg > mic_pkg::CFG_W'(MO)) begin
      n_in = OW'(MO);
    end else begin
      n_in = OW'(order_reg);
    end
    nn_in   = (2*OW)'(n_in) * (2*OW)'(n_in);
    full_in = mic_pkg::order_mask(n_in);
    full_n  = mic_pkg::order_mask(n);
  end

  // current frame and the row it expands along
  always_comb begin
    cur_rows = rows_stk[lv];
    cur_cols = cols_stk[lv];
    cur_c    = c_stk[lv];
    cur_r    = r_stk[lv];
    cur_sum  = sum_stk[lv];
    low_r    = '0;
    for (int i = MO - 1; i >= 0; i--) begin
      if (cur_rows[i]) begin
        low_r = IW'(i);
      end
    end
    k_child = root_k - OW'(lv) - OW'(1);
  end

  // saturate the frame sum to Q16.16
  always_comb begin
    if (&cur_sum[SW-1:VW-1] || ~|cur_sum[SW-1:VW-1]) begin
      sat_sum = cur_sum[VW-1:0];
    end else if (cur_sum[SW-1]) begin
      sat_sum = mic_pkg::VAL_MIN;
    end else begin
      sat_sum = mic_pkg::VAL_MAX;
    end
  end

  // root determinant ready: empty minor at the root, or root frame swept
  always_comb begin
    fin     = 1'b0;
    fin_val = sat_sum;
    if (state == S_CALL && lv == '0 && root_k == '0) begin
      fin     = 1'b1;
      fin_val = mic_pkg::Q_ONE;
    end else if (state == S_SCAN && lv == '0 && cur_c == n) begin
      fin = 1'b1;
    end
  end

  // element for the next multiply: the parent frame on a return, else this one
  always_comb begin
    lv_rd     = (state == S_SCAN && cur_c == n && lv != '0) ? lv - 1'b1 : lv;
    rd_addr_w = (2*OW)'(r_stk[lv_rd]) * (2*OW)'(n) + (2*OW)'(c_stk[lv_rd]);
  end

  // shared multiplier and rounding of the term
  always_comb begin
    mul_res   = rd_elem * child_res;
    rounded   = prod + PW'(32768);
    term      = SW'($signed(rounded[PW-1:FW]));
  end

  // divider operands: (2|num| + |det|) / (2|det|)
  always_comb begin
    cof_abs   = fin_val[VW-1] ? VW'(-fin_val) : VW'(fin_val);
    det_abs   = det[VW-1] ? VW'(-det) : VW'(det);
    div_num   = {cof_abs, {FW{1'b0}}, 1'b0} + NW'(det_abs);
    div_den   = {det_abs, 1'b0};
    div_start = fin && !phase_det && !(fin_val == '0 && 1'b0);
  end

  // clamp the quotient and apply the sign
  always_comb begin
    if (|div_quot[NW-1:VW] || (div_quot[VW-1] && |div_quot[VW-2:0])) begin
      q_clamp = {1'b1, {(VW-1){1'b0}}};
    end else begin
      q_clamp = div_quot[VW-1:0];
    end
    if (q_neg) begin
      q_val = VW'(-q_clamp);
    end else if (q_clamp[VW-1]) begin
      q_val = mic_pkg::VAL_MAX;
    end else begin
      q_val = q_clamp;
    end
  end

  // position of the next inverse element
  always_comb begin
    is_last = (OW'(out_r) == n - OW'(1)) && (OW'(out_c) == n - OW'(1));
    if (OW'(out_c) == n - OW'(1)) begin
      nxt_c = '0;
      nxt_r = out_r + 1'b1;
    end else begin
      nxt_c = out_c + 1'b1;
      nxt_r = out_r;
    end
  end

  mic_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // matrix store: write on each counted element beat, read one element a cycle
  always_ff @(posedge clk) begin
    if (elem_beat && ((2*OW)'(load_count) < nn_in)) begin
      matrix_store[load_count[AW-1:0]] <= elem.element_value;
    end
    rd_elem <= matrix_store[rd_addr_w[AW-1:0]];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_reg <= mic_pkg::CFG_W'(mic_pkg::ORDER_RESET);
    end else if (cfg_valid && cfg_ready) begin
      order_reg <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      load_count   <= '0;
      result_valid <= 1'b0;
      lv           <= '0;
      phase_det    <= 1'b1;
    end else begin
      case (state)
        // collect elements; start the determinant on the last beat
        S_LOAD: begin
          if (elem_beat) begin
            if ((2*OW)'(load_count) < nn_in) begin
              load_count <= load_count + 1'b1;
            end
            if (elem.last_element) begin
              load_count  <= '0;
              n           <= n_in;
              root_k      <= n_in;
              phase_det   <= 1'b1;
              lv          <= '0;
              rows_stk[0] <= full_in;
              cols_stk[0] <= full_in;
              state       <= S_CALL;
            end
          end
        end

        // open a frame
        S_CALL: begin
          if (!fin) begin
            r_stk[lv]   <= low_r;
            sum_stk[lv] <= '0;
            neg_stk[lv] <= 1'b0;
            c_stk[lv]   <= '0;
            state       <= S_SCAN;
          end
        end

        // look for the next column of the frame
        S_SCAN: begin
          if (cur_c == n) begin
            if (lv != '0) begin
              lv        <= lv - 1'b1;
              child_res <= sat_sum;
              state     <= S_MUL;
            end
          end else if (cur_cols[cur_c[IW-1:0]]) begin
            if (k_child == '0) begin
              child_res <= mic_pkg::Q_ONE;
              state     <= S_MUL;
            end else begin
              rows_stk[lv + 1'b1] <= cur_rows & ~(MO'(1) << cur_r);
              cols_stk[lv + 1'b1] <= cur_cols & ~(MO'(1) << cur_c[IW-1:0]);
              lv                  <= lv + 1'b1;
              state               <= S_CALL;
            end
          end else begin
            c_stk[lv] <= cur_c + 1'b1;
          end
        end

        // element times minor
        S_MUL: begin
          prod  <= mul_res;
          state <= S_ACC;
        end

        // add the rounded term with alternating sign
        S_ACC: begin
          sum_stk[lv] <= neg_stk[lv] ? cur_sum - term : cur_sum + term;
          neg_stk[lv] <= !neg_stk[lv];
          c_stk[lv]   <= cur_c + 1'b1;
          state       <= S_SCAN;
        end

        // wait for the quotient, then present the beat
        S_DIV: begin
          if (div_done) begin
            result.inverse_value <= q_val;
            result.out_row       <= XW'(out_r);
            result.out_col       <= XW'(out_c);
            result.singular      <= 1'b0;
            result.last_result   <= is_last;
            result_valid         <= 1'b1;
            state                <= S_OUT;
          end
        end

        // hold the beat until taken, then move to the next element
        S_OUT: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (is_last) begin
              state <= S_LOAD;
            end else begin
              out_r <= nxt_r;
              out_c <= nxt_c;
              if (sing) begin
                result.inverse_value <= '0;
                result.out_row       <= XW'(nxt_r);
                result.out_col       <= XW'(nxt_c);
                result.singular      <= 1'b1;
                result.last_result   <= (OW'(nxt_r) == n - OW'(1)) &&
                                        (OW'(nxt_c) == n - OW'(1));
                result_valid         <= 1'b1;
              end else begin
                rows_stk[0] <= full_n & ~(MO'(1) << nxt_c);
                cols_stk[0] <= full_n & ~(MO'(1) << nxt_r);
                lv          <= '0;
                state       <= S_CALL;
              end
            end
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase

      // root result: determinant or one cofactor
      if (fin) begin
        if (phase_det) begin
          det       <= fin_val;
          sing      <= (fin_val == '0);
          phase_det <= 1'b0;
          root_k    <= n - OW'(1);
          out_r     <= '0;
          out_c     <= '0;
          if (fin_val == '0) begin
            result.inverse_value <= '0;
            result.out_row       <= '0;
            result.out_col       <= '0;
            result.singular      <= 1'b1;
            result.last_result   <= (n == OW'(1));
            result_valid         <= 1'b1;
            state                <= S_OUT;
          end else begin
            rows_stk[0] <= full_n & ~MO'(1);
            cols_stk[0] <= full_n & ~MO'(1);
            lv          <= '0;
            state       <= S_CALL;
          end
        end else begin
          q_neg <= (fin_val != '0) && (fin_val[VW-1] ^ (out_r[0] ^ out_c[0])) ^ det[VW-1];
          state <= S_DIV;
        end
      end
    end
  end

  // checks on the sequencer
  assert property (@(posedge clk) disable iff (rst) elem_ready |-> !result_valid)
    else $error("loading while a result beat is pending");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.singular |-> result.inverse_value == '0)
    else $error("singular beat carries a nonzero value");

  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> c_stk[lv] <= n)
    else $error("column index ran past the order");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.last_result |=> elem_ready)
    else $error("block did not return to loading after the last beat");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the cofactor matrix inverse
// Drives square Q16.16 matrices of several orders through the element
// channel, predicts every inverse element in a local model of the cofactor
// expansion and the division, and checks each result beat in order.
// Directed rows come first, then random matrices under varied back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LIMIT_CYCLES = 10_000_000;
  localparam int  DRAIN_CYCLES = 100;
  localparam int  CFG_PAUSE    = 60;
  localparam int  STORE_N      = mic_pkg::MAX_ORDER * mic_pkg::MAX_ORDER;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] data;
    logic        last;
    logic        typed;
    logic [31:0] typed_value;
    logic        typed_singular;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    elem_valid = 1'b0;
  logic    elem_ready;
  mic_pkg::elem_t   elem = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  mic_pkg::result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [mic_pkg::CFG_W-1:0] cfg_data = '0;

  // local copy of the block state
  longint      mat_store [STORE_N];
  int unsigned fill_count;
  logic [3:0]  order_reg;
  int unsigned cur_n;

  mic_pkg::result_t inverse_queue[$];
  int          errors;
  int          cycles;
  int          items_sent;
  int          results_seen;
  int          matrices_sent;
  int          singular_seen;
  int          stall_pct;
  int          gap_pct;

  matrix_inverse_by_cofactors DUT (
    .clk          (clk),
    .rst          (rst),
    .elem_valid   (elem_valid),
    .elem_ready   (elem_ready),
    .elem         (elem),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Fixed-point helpers of the inverse
  // ---------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_round(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic int unsigned clip_order(logic [3:0] o);
    if (o < 1) return 1;
    if (o > mic_pkg::MAX_ORDER) return mic_pkg::MAX_ORDER;
    return o;
  endfunction

  // determinant of the minor on the given row and column masks
  function automatic longint minor_det(int unsigned rows, int unsigned cols, int unsigned k);
    int unsigned r;
    longint      sum;
    longint      t;
    bit          neg;
    if (k == 0) return 64'sd65536;
    r = 0;
    sum = 0;
    neg = 0;
    while (r < cur_n && !rows[r]) r++;
    for (int unsigned c = 0; c < cur_n; c++) begin
      if (cols[c]) begin
        t = mul_round(mat_store[(r * cur_n + c) % STORE_N],
                      minor_det(rows & ~(1 << r), cols & ~(1 << c), k - 1));
        sum += neg ? -t : t;
        neg = !neg;
      end
    end
    return clamp32(sum);
  endfunction

  function automatic longint div_round(longint num, longint den);
    bit          neg;
    longint unsigned un, ud, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (2 * un + ud) / (2 * ud);
    if (q > 64'd2147483648) q = 64'd2147483648;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  // absorb one accepted element, queue the inverse on a last mark
  task automatic absorb_element(mic_pkg::elem_t e, logic typed, logic [31:0] tv, logic ts);
    int unsigned full;
    longint      det, cof, num;
    bit          sing;
    mic_pkg::result_t res;
    cur_n = clip_order(order_reg);
    if (fill_count < cur_n * cur_n) begin
      mat_store[fill_count % STORE_N] = longint'(e.element_value);
      fill_count++;
    end
    if (!e.last_element) return;
    fill_count = 0;
    matrices_sent++;
    full = (1 << cur_n) - 1;
    det = minor_det(full, full, cur_n);
    sing = (det == 0);
    if (sing) singular_seen++;
    for (int unsigned r = 0; r < cur_n; r++) begin
      for (int unsigned c = 0; c < cur_n; c++) begin
        res = '0;
        if (!sing) begin
          cof = minor_det(full & ~(1 << c), full & ~(1 << r), cur_n - 1);
          num = cof * 64'sd65536;
          if ((r + c) % 2) num = -num;
          res.inverse_value = 32'(div_round(num, det));
        end
        res.out_row     = mic_pkg::POS_W'(r);
        res.out_col     = mic_pkg::POS_W'(c);
        res.singular    = sing;
        res.last_result = (r == cur_n - 1) && (c == cur_n - 1);
        if (typed) begin
          res.inverse_value = tv;
          res.singular      = ts;
        end
        inverse_queue.push_back(res);
      end
    end
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------
  task automatic send_element(logic [31:0] v, logic l, logic typed = 0,
                              logic [31:0] tv = '0, logic ts = 0);
    mic_pkg::elem_t e;
    e.element_value = v;
    e.last_element  = l;
    elem_valid <= 1'b1;
    elem       <= e;
    do @(posedge clk); while (!elem_ready);
    absorb_element(e, typed, tv, ts);
    items_sent++;
    // drop valid for a short gap now and then
    if ($urandom_range(99) < gap_pct) begin
      elem_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    elem_valid <= 1'b0;
    @(posedge clk);
    while (inverse_queue.size() != 0) @(posedge clk);
    repeat (CFG_PAUSE) @(posedge clk);
  endtask

  task automatic write_order(logic [3:0] o);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= o;
    do @(posedge clk); while (!cfg_ready);
    order_reg = o;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_element(int mode);
    case (mode)
      0:       return 32'($signed($urandom_range(8)) - 4) << 16;
      1:       return $urandom();
      2:       return '0;
      default: return 32'($signed($urandom_range(16'hFFFF, 0)) - 32768) <<< 2;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    mic_pkg::result_t want;
    cycles <= cycles + 1;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (inverse_queue.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = inverse_queue.pop_front();
        if (result.inverse_value !== want.inverse_value)
          report_mismatch($sformatf("value %h want %h at (%0d,%0d)",
            result.inverse_value, want.inverse_value, want.out_row, want.out_col));
        if (result.out_row !== want.out_row)
          report_mismatch($sformatf("row %0d want %0d", result.out_row, want.out_row));
        if (result.out_col !== want.out_col)
          report_mismatch($sformatf("col %0d want %0d", result.out_col, want.out_col));
        if (result.singular !== want.singular)
          report_mismatch($sformatf("singular %b want %b", result.singular, want.singular));
        if (result.last_result !== want.last_result)
          report_mismatch($sformatf("last %b want %b", result.last_result, want.last_result));
      end
    end
    // hold back the result side at the current rate
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycles, inverse_queue.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  stim_row_t directed[$];

  task automatic add_row(row_kind_t k, logic [31:0] d, logic l = 0, logic t = 0,
                         logic [31:0] tv = '0, logic ts = 0);
    directed.push_back('{k, d, l, t, tv, ts});
  endtask

  initial begin
    int budget;
    int n_el, cnt, mode;
    logic [3:0] ord;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    results_seen = 0;
    matrices_sent = 0;
    singular_seen = 0;
    fill_count = 0;
    order_reg = 4'(mic_pkg::ORDER_RESET);
    stall_pct = 0;
    gap_pct = 0;
    foreach (mat_store[i]) mat_store[i] = 0;

    // identity of order 4 fills the whole store
    for (int i = 0; i < 16; i++)
      add_row(ROW_ITEM, (i % 5 == 0) ? 32'h0001_0000 : 32'h0, i == 15);
    // order one: unit, zero, minus one, extremes
    add_row(ROW_CFG, 1);
    add_row(ROW_ITEM, 32'h0001_0000, 1, 1, 32'h0001_0000, 0);
    add_row(ROW_ITEM, 32'h0000_0000, 1, 1, 32'h0000_0000, 1);
    add_row(ROW_ITEM, 32'hFFFF_0000, 1, 1, 32'hFFFF_0000, 0);
    add_row(ROW_ITEM, 32'h8000_0000, 1);
    add_row(ROW_ITEM, 32'h7FFF_FFFF, 1);
    add_row(ROW_ITEM, 32'h0000_0001, 1);
    // order zero acts as one
    add_row(ROW_CFG, 0);
    add_row(ROW_ITEM, 32'h0002_0000, 1, 1, 32'h0000_8000, 0);
    // order two with one extra element that carries the mark
    add_row(ROW_CFG, 2);
    add_row(ROW_ITEM, 32'h0003_0000, 0);
    add_row(ROW_ITEM, 32'h0001_0000, 0);
    add_row(ROW_ITEM, 32'h0002_0000, 0);
    add_row(ROW_ITEM, 32'h0004_0000, 0);
    add_row(ROW_ITEM, 32'h7FFF_FFFF, 1);
    // order above the maximum with an early mark
    add_row(ROW_CFG, 15);
    add_row(ROW_ITEM, 32'h0002_0000, 0);
    add_row(ROW_ITEM, 32'hFFFF_8000, 1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table
    gap_pct = 8;
    stall_pct = 30;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_order(directed[i].data[3:0]);
      else send_element(directed[i].data, directed[i].last, directed[i].typed,
                        directed[i].typed_value, directed[i].typed_singular);
    end

    // random matrices under three idling profiles
    for (int prof = 0; prof < 3; prof++) begin
      gap_pct   = (prof == 0) ? 8 : (prof == 1) ? 88 : 0;
      stall_pct = (prof == 0) ? 88 : (prof == 1) ? 8 : 0;
      for (int ph = 0; ph < 6; ph++) begin
        case ($urandom_range(9))
          0:       ord = 0;
          1:       ord = 1;
          2, 3, 4: ord = 2;
          5, 6:    ord = 3;
          7:       ord = 4;
          8:       ord = 4'($urandom_range(15, 5));
          default: ord = 2;
        endcase
        if (prof == 2 && ph == 5) ord = 4;
        write_order(ord);
        budget = items_sent + 24;
        while (items_sent < budget) begin
          cur_n = clip_order(order_reg);
          n_el = cur_n * cur_n;
          cnt = $urandom_range(99);
          if (cnt < 10) n_el = $urandom_range(n_el, 1);
          else if (cnt < 18) n_el = n_el + $urandom_range(3, 1);
          mode = $urandom_range(3);
          for (int k = 0; k < n_el; k++)
            send_element(random_element(mode), k == n_el - 1);
          // in one phase, let every pending result drain before going on
          if (prof == 1 && ph == 2 && items_sent >= budget - 14) begin
            elem_valid <= 1'b0;
            @(posedge clk);
            while (inverse_queue.size() != 0) @(posedge clk);
          end
        end
      end
    end

    // drain
    elem_valid <= 1'b0;
    @(posedge clk);
    while (inverse_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d elements in %0d matrices, orders 0..15, %0d singular",
             items_sent, matrices_sent, singular_seen);
    $display("checked %0d result beats under three back-pressure profiles, %0d errors",
             results_seen, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/mic_pkg.sv
design/mic_div.sv
design/matrix_inverse_by_cofactors.sv
bench/tb_top.sv
